// ===== design/dwbc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the direct-mapped write-back cache
// no dependencies

package dwbc_pkg;

   localparam int ADDR_W     = 11;
   localparam int DATA_W     = 16;
   localparam int LOW_BYTE_W = 8;

   localparam int LINES_DEF          = 16;
   localparam int WORDS_PER_LINE_DEF = 16;
   localparam int MEMORY_WORDS_DEF   = 2048;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

endpackage

// ===== design/dwbc_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces, valid/ready handshake
// depends on dwbc_pkg

interface dwbc_req_if;
   import dwbc_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic [ADDR_W-1:0]   word_address;
   logic [DATA_W-1:0]   write_value;

   modport source (output valid, output operation, output word_address, output write_value,
                   input ready);
   modport sink   (input valid, input operation, input word_address, input write_value,
                   output ready);
endinterface

interface dwbc_rsp_if;
   import dwbc_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_value;
   logic                hit;

   modport source (output valid, output read_value, output hit, input ready);
   modport sink   (input valid, input read_value, input hit, output ready);
endinterface

// ===== design/direct_mapped_writeback_cache.sv =====
`timescale 1ns / 1ps
// direct-mapped write-back, write-allocate cache with its backing memory inside
// depends on dwbc_pkg, dwbc_if (dwbc_req_if, dwbc_rsp_if) and dwbc_ram
//
//   port   dir   handshake       carries
//   req    in    valid/ready     operation, word_address, write_value
//   rsp    out   valid/ready     read_value, hit
//
// read hit: ST_CHECK, ST_RD_WAIT, ST_DONE, then the response; write hit: ST_CHECK, ST_DONE
// a miss adds a line fill in ST_FILL, and a dirty victim a write-back in ST_EVICT before it;
// both walk the line through the word-per-cycle memory ports
// after reset the backing memory is initialized word by word, req.ready low
// one request is in flight at a time; a new one is taken while the last response waits
// a stalled response holds the sequencer in its final state until the output is free

module direct_mapped_writeback_cache #(
   parameter int LINES          = dwbc_pkg::LINES_DEF,
   parameter int WORDS_PER_LINE = dwbc_pkg::WORDS_PER_LINE_DEF,
   parameter int MEMORY_WORDS   = dwbc_pkg::MEMORY_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dwbc_req_if.sink   req,
   dwbc_rsp_if.source rsp
);
   import dwbc_pkg::*;

   // address split, wrapping to the backing memory size first
   localparam int OFF_W  = $clog2(WORDS_PER_LINE);
   localparam int IDX_W  = $clog2(LINES);
   localparam int MEM_AW = $clog2(MEMORY_WORDS);
   localparam int EFF_AW = (MEM_AW < ADDR_W) ? MEM_AW : ADDR_W;
   localparam int TAG_W  = EFF_AW - OFF_W - IDX_W;
   localparam int SLOT_W = IDX_W + OFF_W;
   localparam int CNT_W  = OFF_W + 1;

   typedef enum logic [7:0] {
      ST_INIT    = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_CHECK   = 8'b0000_0100,
      ST_EVICT   = 8'b0000_1000,
      ST_FILL    = 8'b0001_0000,
      ST_ACCESS  = 8'b0010_0000,
      ST_RD_WAIT = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   // sequencer
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MEM_AW-1:0]  init_ff, init_in;

   // captured request
   op_type             op_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [DATA_W-1:0]  wval_ff;
   logic [EFF_AW-1:0]  eff_addr;

   // result
   logic               hit_ff, hit_in;
   logic [DATA_W-1:0]  res_ff, res_in;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_hit_ff;
   logic               rsp_free;

   // per-line bookkeeping, small enough for flops
   logic               line_valid_ff [LINES];
   logic               line_dirty_ff [LINES];
   logic [TAG_W-1:0]   line_tag_ff   [LINES];

   // memory ports
   logic               c_wr_en, c_rd_en;
   logic [SLOT_W-1:0]  c_wr_addr, c_rd_addr;
   logic [DATA_W-1:0]  c_wr_data, c_rd_data;
   logic               b_wr_en, b_rd_en;
   logic [MEM_AW-1:0]  b_wr_addr, b_rd_addr;
   logic [DATA_W-1:0]  b_wr_data, b_rd_data;

   logic               req_fire;
   logic               hit_now;
   logic               do_access;
   logic               cnt_last;
   logic [OFF_W-1:0]   cnt_prev;
   logic               fill_done;

   assign req.ready   = (state_ff == ST_IDLE);
   assign req_fire    = req.valid && req.ready;
   assign eff_addr    = req.word_address[EFF_AW-1:0];

   assign hit_now     = line_valid_ff[idx_ff] && (line_tag_ff[idx_ff] == tag_ff);
   assign do_access   = ((state_ff == ST_CHECK) && hit_now) || (state_ff == ST_ACCESS);
   assign cnt_last    = (cnt_ff == CNT_W'(WORDS_PER_LINE));
   assign cnt_prev    = OFF_W'(cnt_ff - CNT_W'(1));
   assign fill_done   = (state_ff == ST_FILL) && cnt_last;
   assign rsp_free    = !rsp_valid_ff || rsp.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = rsp_data_ff;
   assign rsp.hit        = rsp_hit_ff;

   // line data store
   dwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINES * WORDS_PER_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (c_rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   // backing word memory
   dwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEMORY_WORDS)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      init_in   = init_ff;
      hit_in    = hit_ff;
      res_in    = res_ff;
      c_wr_en   = 1'b0;
      c_wr_addr = {idx_ff, off_ff};
      c_wr_data = wval_ff;
      c_rd_en   = 1'b0;
      c_rd_addr = {idx_ff, off_ff};
      b_wr_en   = 1'b0;
      b_wr_addr = init_ff;
      b_wr_data = DATA_W'(init_ff[LOW_BYTE_W-1:0]);
      b_rd_en   = 1'b0;
      b_rd_addr = MEM_AW'({tag_ff, idx_ff, cnt_ff[OFF_W-1:0]});

      case (state_ff)
         ST_INIT: begin
            // each backing word starts as the low byte of its address
            b_wr_en = 1'b1;
            init_in = init_ff + MEM_AW'(1);
            if (init_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            hit_in = hit_now;
            cnt_in = '0;
            if (!hit_now) begin
               // only a valid dirty victim goes back to memory
               if (line_valid_ff[idx_ff] && line_dirty_ff[idx_ff]) begin
                  state_in = ST_EVICT;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_EVICT: begin
            // read word n from the line while word n-1 lands in memory
            c_rd_addr = {idx_ff, cnt_ff[OFF_W-1:0]};
            c_rd_en   = !cnt_last;
            b_wr_en   = (cnt_ff != '0);
            b_wr_addr = MEM_AW'({line_tag_ff[idx_ff], idx_ff, cnt_prev});
            b_wr_data = c_rd_data;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FILL: begin
            b_rd_en   = !cnt_last;
            c_wr_en   = (cnt_ff != '0);
            c_wr_addr = {idx_ff, cnt_prev};
            c_wr_data = b_rd_data;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_ACCESS;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_ACCESS: begin
            // word access handled below, shared with the hit path
         end
         ST_RD_WAIT: begin
            res_in   = c_rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // word access on the now-resident line
      if (do_access) begin
         if (op_ff == OP_WRITE) begin
            c_wr_en   = 1'b1;
            c_wr_addr = {idx_ff, off_ff};
            c_wr_data = wval_ff;
            res_in    = wval_ff;
            state_in  = ST_DONE;
         end else begin
            c_rd_en   = 1'b1;
            c_rd_addr = {idx_ff, off_ff};
            state_in  = ST_RD_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         init_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         line_valid_ff <= '{default: 1'b0};
         line_dirty_ff <= '{default: 1'b0};
         line_tag_ff   <= '{default: '0};
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         init_ff  <= init_in;

         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // freshly filled line is valid and clean
         if (fill_done) begin
            line_valid_ff[idx_ff] <= 1'b1;
            line_dirty_ff[idx_ff] <= 1'b0;
            line_tag_ff[idx_ff]   <= tag_ff;
         end
         if (do_access && (op_ff == OP_WRITE)) begin
            line_dirty_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      res_ff <= res_in;
      if (req_fire) begin
         op_ff   <= req.operation;
         off_ff  <= eff_addr[OFF_W-1:0];
         idx_ff  <= eff_addr[OFF_W +: IDX_W];
         tag_ff  <= eff_addr[EFF_AW-1 -: TAG_W];
         wval_ff <= req.write_value;
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_data_ff <= res_ff;
         rsp_hit_ff  <= hit_ff;
      end
   end

   // a hit never touches the backing memory
   a_hit_no_miss_walk: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CHECK) && hit_now) |=> ((state_ff != ST_EVICT) && (state_ff != ST_FILL)))
      else $error("hit entered the miss path");

   // after a fill the line holds the requested tag
   a_fill_tags_line: assert property (@(posedge clock) disable iff (reset)
      fill_done |=> (line_valid_ff[idx_ff] && (line_tag_ff[idx_ff] == tag_ff)))
      else $error("filled line not valid with request tag");

   // a completed write leaves its line dirty
   a_write_dirty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (op_ff == OP_WRITE)) |-> line_dirty_ff[idx_ff])
      else $error("write left line clean");

   // line walk counter stays within one line
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVICT) || (state_ff == ST_FILL)) |-> (cnt_ff <= CNT_W'(WORDS_PER_LINE)))
      else $error("line walk counter overran");

endmodule

// ===== design/dwbc_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module dwbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb_direct_mapped_writeback_cache.sv =====
`timescale 1ns / 1ps
// self-checking testbench for direct_mapped_writeback_cache: directed and random accesses
// depends on dwbc_pkg, dwbc_if (dwbc_req_if, dwbc_rsp_if) and the cache rtl

module tb_direct_mapped_writeback_cache;
   import dwbc_pkg::*;

   // address split: tag | line index | word offset
   localparam int OFFSET_W = $clog2(WORDS_PER_LINE_DEF);
   localparam int INDEX_W  = $clog2(LINES_DEF);
   localparam int TAG_W    = ADDR_W - OFFSET_W - INDEX_W;

   localparam int RANDOM_REQUESTS = 2000;
   // tail after the last response: room for a write-back and a fill, plus slack
   localparam int TAIL_CYCLES     = 2 * WORDS_PER_LINE_DEF + 20;
   // run limit in ns, covering the slowest run including the memory init pass
   localparam int unsigned RUN_LIMIT_NS = 10_000_000;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              hit;
   } access_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_LONG,
      STALL_RARE
   } stall_mode_type;

   logic clock;
   logic reset;

   dwbc_req_if req_bus ();
   dwbc_rsp_if rsp_bus ();

   direct_mapped_writeback_cache i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // predicted cache state, kept in step with every accepted request
   // ---------------------------------------------------------------------
   logic              tag_valid  [LINES_DEF];
   logic              tag_dirty  [LINES_DEF];
   logic [TAG_W-1:0]  tag_store  [LINES_DEF];
   logic [DATA_W-1:0] data_store [LINES_DEF*WORDS_PER_LINE_DEF];
   logic [DATA_W-1:0] mem_image  [MEMORY_WORDS_DEF];

   access_result_type expected_results[$];
   int unsigned       error_count;

   // sender burst bookkeeping
   int unsigned burst_left;
   bit          gaps_enabled;

   // tags that fight over the same lines in the random phase
   logic [TAG_W-1:0] hot_tag_a;
   logic [TAG_W-1:0] hot_tag_b;

   function automatic void clear_cache_image();
      for (int l = 0; l < LINES_DEF; l++) begin
         tag_valid[l] = 1'b0;
         tag_dirty[l] = 1'b0;
         tag_store[l] = '0;
      end
      for (int w = 0; w < LINES_DEF * WORDS_PER_LINE_DEF; w++)
         data_store[w] = '0;
      // backing memory powers up with the low byte of each word address
      for (int a = 0; a < MEMORY_WORDS_DEF; a++)
         mem_image[a] = {{(DATA_W-LOW_BYTE_W){1'b0}}, a[LOW_BYTE_W-1:0]};
   endfunction

   // one access: evict and fill on a miss, then read or write the addressed word
   function automatic access_result_type predict_access(input op_type           op,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [DATA_W-1:0] wdata);
      logic [OFFSET_W-1:0] offset;
      logic [INDEX_W-1:0]  index;
      logic [TAG_W-1:0]    tag;
      logic [ADDR_W-1:0]   victim_base;
      logic [ADDR_W-1:0]   fill_base;
      access_result_type   r;
      {tag, index, offset} = addr;
      r.hit = tag_valid[index] && (tag_store[index] == tag);
      if (!r.hit) begin
         // only a valid and dirty victim goes back to memory, whole line
         if (tag_valid[index] && tag_dirty[index]) begin
            victim_base = {tag_store[index], index, {OFFSET_W{1'b0}}};
            for (int w = 0; w < WORDS_PER_LINE_DEF; w++)
               mem_image[ADDR_W'(victim_base + ADDR_W'(w))] =
                  data_store[{index, OFFSET_W'(w)}];
         end
         fill_base = {tag, index, {OFFSET_W{1'b0}}};
         for (int w = 0; w < WORDS_PER_LINE_DEF; w++)
            data_store[{index, OFFSET_W'(w)}] = mem_image[ADDR_W'(fill_base + ADDR_W'(w))];
         tag_valid[index] = 1'b1;
         tag_dirty[index] = 1'b0;
         tag_store[index] = tag;
      end
      if (op == OP_WRITE) begin
         data_store[{index, offset}] = wdata;
         tag_dirty[index] = 1'b1;
      end
      r.read_value = data_store[{index, offset}];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // clock and run limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS * 1ns);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // response side: random stall modes, each held for a randomly drawn number of clock cycles
   // ---------------------------------------------------------------------
   initial begin : response_stall_pattern
      stall_mode_type mode;
      int unsigned    mode_left;
      int unsigned    hold;
      rsp_bus.ready = 1'b0;
      mode          = STALL_NONE;
      mode_left     = 0;
      hold          = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         case (mode)
            STALL_NONE: begin
               rsp_bus.ready = 1'b1;
            end
            STALL_COIN: begin
               rsp_bus.ready = ($urandom_range(0, 1) == 1);
            end
            STALL_LONG: begin
               // alternate short open windows with long closed ones
               if (hold > 0) begin
                  hold--;
               end else begin
                  rsp_bus.ready = ~rsp_bus.ready;
                  hold = rsp_bus.ready ? $urandom_range(0, 3) : $urandom_range(1, 20);
               end
            end
            default: begin
               rsp_bus.ready = ($urandom_range(0, 7) != 0);
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // response checker: each accepted response against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_response
      access_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("response with nothing outstanding: read_value %h hit %b",
                   rsp_bus.read_value, rsp_bus.hit);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.read_value !== want.read_value) begin
               $error("read_value mismatch: expected %h, actual %h",
                      want.read_value, rsp_bus.read_value);
               error_count++;
            end
            if (rsp_bus.hit !== want.hit) begin
               $error("hit mismatch: expected %b, actual %b", want.hit, rsp_bus.hit);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // called at a falling edge; returns at a falling edge with valid still high so
   // back-to-back requests keep it asserted
   task automatic send_request(input op_type           op,
                               input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (!gaps_enabled || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid        = 1'b1;
      req_bus.operation    = op;
      req_bus.word_address = addr;
      req_bus.write_value  = wdata;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_access(op, addr, wdata));
      @(negedge clock);
   endtask

   // drop valid and hold off until every predicted response has come back
   task automatic wait_for_drain();
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] recent);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'($urandom_range(0, MEMORY_WORDS_DEF - 1));
      case ($urandom_range(0, 3))
         0: begin
            // anywhere in memory
         end
         1: begin
            // same line as the last access, mostly hits
            a = recent;
            a[OFFSET_W-1:0] = OFFSET_W'($urandom);
         end
         default: begin
            // two tags on four lines: lots of conflict misses and write-backs
            a[ADDR_W-1 -: TAG_W]   = ($urandom_range(0, 1) == 1) ? hot_tag_a : hot_tag_b;
            a[OFFSET_W +: INDEX_W] = INDEX_W'($urandom_range(0, 3));
         end
      endcase
      return a;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // cold lines: misses on invalid lines fill from the initial memory pattern,
   // covering the lowest and the highest word address
   task automatic test_cold_reads();
      send_request(OP_READ, 11'h000, 16'h0000);
      send_request(OP_READ, 11'h00F, 16'hFFFF);   // hit, last offset, value ignored
      send_request(OP_READ, 11'h7FF, 16'h1234);   // top of memory, last line, highest tag
      send_request(OP_READ, 11'h7F0, 16'h0000);   // hit
      wait_for_drain();
   endtask

   // write allocate, then a conflicting tag forces a dirty write-back of the whole line
   task automatic test_write_back();
      send_request(OP_WRITE, 11'h123, 16'hFFFF);  // write miss on an invalid line
      send_request(OP_WRITE, 11'h124, 16'h0000);  // write hit
      send_request(OP_WRITE, 11'h12F, 16'h8001);
      send_request(OP_READ,  11'h123, 16'h0000);  // read back, hit
      send_request(OP_WRITE, 11'h223, 16'hA5A5);  // valid line, other tag: evict dirty
      send_request(OP_READ,  11'h123, 16'h0000);  // evicts the new dirty line, old data back
      send_request(OP_READ,  11'h12F, 16'h0000);
      send_request(OP_READ,  11'h223, 16'h0000);  // second write-back survived too
      wait_for_drain();
   endtask

   // read misses leave lines clean, so replacing them must not touch memory
   task automatic test_clean_victim();
      send_request(OP_READ, 11'h350, 16'h0000);   // read miss, line stays clean
      send_request(OP_READ, 11'h450, 16'h0000);   // clean victim dropped
      send_request(OP_READ, 11'h35A, 16'h0000);   // refill sees the original memory
      send_request(OP_WRITE, 11'h45B, 16'h7FFE);  // clean victim replaced by a write
      send_request(OP_READ, 11'h45B, 16'h0000);
      wait_for_drain();
   endtask

   // long random mix, with a full drain in the middle and a stretch without gaps
   task automatic test_random_traffic();
      logic [ADDR_W-1:0] addr;
      addr      = '0;
      hot_tag_a = TAG_W'($urandom);
      hot_tag_b = TAG_W'($urandom);
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) begin
            // sender holds off until the cache has answered everything
            wait_for_drain();
            hot_tag_a = TAG_W'($urandom);
            hot_tag_b = TAG_W'($urandom);
         end
         gaps_enabled = !(n >= 1400 && n < 1700);
         addr = pick_address(addr);
         send_request(op_type'($urandom_range(0, 1)), addr, pick_value());
      end
      gaps_enabled = 1'b1;
      wait_for_drain();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_READ;
      req_bus.word_address = '0;
      req_bus.write_value  = '0;
      error_count          = 0;
      burst_left           = 0;
      gaps_enabled         = 1'b1;
      hot_tag_a            = '0;
      hot_tag_b            = '0;
      clear_cache_image();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // the memory init pass after reset keeps ready low; send_request waits it out
      test_cold_reads();
      test_write_back();
      test_clean_victim();
      test_random_traffic();

      // catch any stray response after the last expected one
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== direct_mapped_writeback_cache.f =====
design/dwbc_pkg.sv
design/dwbc_if.sv
design/dwbc_ram.sv
design/direct_mapped_writeback_cache.sv
tb/sv/tb_direct_mapped_writeback_cache.sv
